/* rtl/core/assert_macros.svh */
// Assertion macros shared by the text formatter RTL.
// No dependencies; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, off while arst_n is low.
`define CTF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge of clk.
`define CTF_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* rtl/core/ctf_pkg.sv */
// Shared types, register indexes and character constants of the text formatter.
// No dependencies; imported by every module of the formatter.
package ctf_pkg;

	localparam int NUMBER_DIGITS_DEF = 6;
	localparam int QUEUE_DEPTH_DEF   = 2;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_MODE      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SQUEEZE_BLANK    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_ENDS        = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_TABS        = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_NONPRINTING = 3'd4;

	localparam logic [1:0] NUM_OFF   = 2'd0;
	localparam logic [1:0] NUM_ALL   = 2'd1;

	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_NL        = 8'h0A;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_DOLLAR    = 8'h24;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_QMARK     = 8'h3F;
	localparam logic [7:0] CH_I         = 8'h49;
	localparam logic [7:0] CH_CARET     = 8'h5E;
	localparam logic [7:0] CH_DEL       = 8'h7F;
	localparam logic [7:0] CTRL_LIMIT   = 8'd32;
	localparam logic [7:0] CARET_OFFSET = 8'd64;
	localparam logic [3:0] DIGIT_NINE   = 4'd9;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       file_start;
	} ctf_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} ctf_out_t;

	typedef struct packed {
		logic [1:0] number_mode;
		logic       squeeze_blank;
		logic       show_ends;
		logic       show_tabs;
		logic       show_nonprinting;
	} ctf_cfg_t;

	// One classified request: optional line number, then one or two body bytes.
	typedef struct packed {
		logic       num_en;
		logic       body_two;
		logic [7:0] body0;
		logic [7:0] body1;
	} ctf_job_t;

	typedef enum logic [1:0] {
		PH_NUM,
		PH_TAB,
		PH_BODY0,
		PH_BODY1
	} ctf_phase_t;

endpackage

/* rtl/core/cat_text_stream_formatter.sv */
// Text formatter top: an accepted request is written into the job queue, and its
// bytes then pass through the back end's output register, one output byte per
// cycle while the sink is ready. A request yields one or two body bytes, led on a
// numbered line by NUMBER_DIGITS digits and a tab, and no output bytes when a
// repeated blank line is squeezed. Reset clears config to zero, the line count
// to zero and the line state to "at line start"; no clearing pass is needed.
module cat_text_stream_formatter import ctf_pkg::*; #(
	parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF,
	parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   text_valid,
	output logic                   text_ready,
	input  ctf_in_t                text,
	output logic                   fmt_valid,
	input  logic                   fmt_ready,
	output ctf_out_t               fmt
);

	// Queue entry: the line number snapshot above the classified job.
	localparam int JW = $bits(ctf_job_t);
	localparam int QW = JW + 4 * NUMBER_DIGITS;

	ctf_cfg_t                   cfg_q;
	logic                       q_full;
	logic                       q_push;
	ctf_job_t                   push_job;
	logic [4*NUMBER_DIGITS-1:0] push_digits;
	logic                       q_pop;
	logic                       head_valid;
	logic [QW-1:0]              head_data;
	ctf_job_t                   head_job;

	// Configuration registers: the user must write them only while no request is in flight,
	// so no request ever sees a change halfway through; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NUMBER_MODE:      cfg_q.number_mode      <= cfg_data;
				CFG_SQUEEZE_BLANK:    cfg_q.squeeze_blank    <= cfg_data[0];
				CFG_SHOW_ENDS:        cfg_q.show_ends        <= cfg_data[0];
				CFG_SHOW_TABS:        cfg_q.show_tabs        <= cfg_data[0];
				CFG_SHOW_NONPRINTING: cfg_q.show_nonprinting <= cfg_data[0];
				default: begin
					// write to an unused index: drop it
				end
			endcase
		end
	end

	// Front end: accept, count lines, classify, push.
	ctf_front #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.text_valid (text_valid),
		.text_ready (text_ready),
		.text       (text),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_job      (push_job),
		.q_digits   (push_digits)
	);

	// Short queue lets the front keep taking requests while the back end
	// spells out a line number or waits on a stalled sink.
	ctf_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  ({push_digits, push_job}),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	assign head_job = head_data[JW-1:0];

	// Back end: one byte per cycle into the output register while the sink is ready.
	ctf_back #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_job    (head_job),
		.head_digits (head_data[QW-1:JW]),
		.pop         (q_pop),
		.fmt_valid   (fmt_valid),
		.fmt_ready   (fmt_ready),
		.fmt         (fmt)
	);

endmodule

/* rtl/core/ctf_front.sv */
// Front end: accepts text requests, tracks line state and the BCD line count,
// and turns each request into a job for the queue. Depends on ctf_pkg.
module ctf_front import ctf_pkg::*; #(
	parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ctf_cfg_t                   cfg,
	input  logic                       text_valid,
	output logic                       text_ready,
	input  ctf_in_t                    text,
	input  logic                       q_full,
	output logic                       q_push,
	output ctf_job_t                   q_job,
	output logic [4*NUMBER_DIGITS-1:0] q_digits
);

	localparam int CW = 4 * NUMBER_DIGITS;

	logic          als_q;
	logic          pb_q;
	logic [CW-1:0] count_q;

	logic          accept;
	logic          als_eff;
	logic          pb_eff;
	logic [CW-1:0] count_eff;
	logic [CW-1:0] count_inc;
	logic          full;
	logic          carry;
	logic          newline;
	logic          squeeze;
	logic          num_en;
	logic [7:0]    c;
	logic [3:0]    d;

	assign text_ready = !q_full;
	assign accept     = text_valid && text_ready;
	assign c          = text.data_byte;
	assign newline    = (c == CH_NL);

	always_comb begin
		als_eff   = text.file_start ? 1'b1 : als_q;
		pb_eff    = text.file_start ? 1'b0 : pb_q;
		count_eff = text.file_start ? '0 : count_q;

		// saturating BCD increment
		full      = 1'b1;
		carry     = 1'b1;
		count_inc = count_eff;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			d = count_eff[4*i +: 4];
			if (d != DIGIT_NINE) begin
				full = 1'b0;
			end
			if (carry) begin
				if (d == DIGIT_NINE) begin
					count_inc[4*i +: 4] = 4'd0;
				end else begin
					count_inc[4*i +: 4] = d + 4'd1;
					carry = 1'b0;
				end
			end
		end
		if (full) begin
			count_inc = count_eff;
		end

		squeeze = newline && als_eff && pb_eff && cfg.squeeze_blank;
		num_en  = als_eff && ((cfg.number_mode == NUM_ALL) ||
			(cfg.number_mode[1] && !newline));

		q_job.num_en   = num_en;
		q_job.body_two = 1'b0;
		q_job.body0    = c;
		q_job.body1    = CH_NL;
		if (newline) begin
			q_job.body_two = cfg.show_ends;
			q_job.body0    = cfg.show_ends ? CH_DOLLAR : CH_NL;
		end else if (c == CH_TAB) begin
			if (cfg.show_tabs) begin
				q_job.body_two = 1'b1;
				q_job.body0    = CH_CARET;
				q_job.body1    = CH_I;
			end
		end else if (cfg.show_nonprinting && c < CTRL_LIMIT) begin
			q_job.body_two = 1'b1;
			q_job.body0    = CH_CARET;
			q_job.body1    = c + CARET_OFFSET;
		end else if (cfg.show_nonprinting && c == CH_DEL) begin
			q_job.body_two = 1'b1;
			q_job.body0    = CH_CARET;
			q_job.body1    = CH_QMARK;
		end

		q_digits = num_en ? count_inc : count_eff;
		q_push   = accept && !squeeze;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			als_q   <= 1'b1;
			pb_q    <= 1'b0;
			count_q <= '0;
		end else if (accept) begin
			// a dropped line leaves the count as it stands after any file restart
			count_q <= squeeze ? count_eff : q_digits;
			if (squeeze) begin
				// drop the line, keep state as it stands after any file restart
				als_q <= als_eff;
				pb_q  <= pb_eff;
			end else if (newline) begin
				als_q <= 1'b1;
				pb_q  <= als_eff;
			end else begin
				als_q <= 1'b0;
				pb_q  <= pb_eff;
			end
		end
	end

endmodule

/* rtl/core/ctf_queue.sv */
// Short job queue between front end and back end, register based.
// Depends on ctf_pkg for the default depth and on assert_macros.svh.
module ctf_queue import ctf_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);

	`include "assert_macros.svh"

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    cnt_q;

	assign full       = (cnt_q == NW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`CTF_ASSERT_NEVER(a_no_push_full, push && full, "queue push while full")
	`CTF_ASSERT_NEVER(a_no_pop_empty, pop && !head_valid, "queue pop while empty")
	`CTF_ASSERT(a_cnt_bound, cnt_q <= NW'(DEPTH), "queue count out of range")

endmodule

/* rtl/core/ctf_back.sv */
// Back end: walks the head job byte by byte (digits, tab, body) into the
// output register. Depends on ctf_pkg and assert_macros.svh.
module ctf_back import ctf_pkg::*; #(
	parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       head_valid,
	input  ctf_job_t                   head_job,
	input  logic [4*NUMBER_DIGITS-1:0] head_digits,
	output logic                       pop,
	output logic                       fmt_valid,
	input  logic                       fmt_ready,
	output ctf_out_t                   fmt
);

	`include "assert_macros.svh"

	localparam int DW = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

	ctf_phase_t    phase_q;
	ctf_phase_t    phase_next;
	ctf_phase_t    cur;
	logic          start_q;
	logic [DW-1:0] digit_q;
	logic          seen_q;
	logic          fmt_valid_q;
	ctf_out_t      fmt_q;

	logic          load;
	logic [3:0]    digit;
	logic          seen;
	ctf_out_t      nxt;

	assign load      = head_valid && (!fmt_valid_q || fmt_ready);
	assign pop       = load && nxt.last;
	assign fmt_valid = fmt_valid_q;
	assign fmt       = fmt_q;

	always_comb begin
		cur = start_q ? (head_job.num_en ? PH_NUM : PH_BODY0) : phase_q;
		digit = head_digits[digit_q*4 +: 4];
		seen  = seen_q || (digit != 4'd0) || (digit_q == '0);
		nxt.out_byte = head_job.body0;
		nxt.last     = 1'b0;
		phase_next   = cur;
		case (cur)
			PH_NUM: begin
				// blank leading zeros, always show the ones digit
				nxt.out_byte = seen ? (CH_ZERO + {4'd0, digit}) : CH_SPACE;
				phase_next   = (digit_q == '0) ? PH_TAB : PH_NUM;
			end
			PH_TAB: begin
				nxt.out_byte = CH_TAB;
				phase_next   = PH_BODY0;
			end
			PH_BODY0: begin
				nxt.out_byte = head_job.body0;
				nxt.last     = !head_job.body_two;
				phase_next   = PH_BODY1;
			end
			PH_BODY1: begin
				nxt.out_byte = head_job.body1;
				nxt.last     = 1'b1;
				phase_next   = PH_BODY1;
			end
			default: begin
				nxt.out_byte = head_job.body0;
				nxt.last     = 1'b1;
				phase_next   = PH_BODY0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NUM;
			start_q <= 1'b1;
			digit_q <= DW'(NUMBER_DIGITS - 1);
			seen_q  <= 1'b0;
		end else if (load) begin
			if (nxt.last) begin
				start_q <= 1'b1;
				digit_q <= DW'(NUMBER_DIGITS - 1);
				seen_q  <= 1'b0;
			end else begin
				start_q <= 1'b0;
				phase_q <= phase_next;
				if (cur == PH_NUM) begin
					seen_q <= seen;
					if (digit_q != '0) begin
						digit_q <= digit_q - 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_valid_q <= 1'b0;
		end else if (load) begin
			fmt_valid_q <= 1'b1;
		end else if (fmt_ready) begin
			fmt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			fmt_q <= nxt;
		end
	end

	`CTF_ASSERT(a_pop_marks_last, pop |=> (fmt_valid_q && fmt_q.last),
		"job retired without a last byte")
	`CTF_ASSERT(a_num_needs_en, (load && cur == PH_NUM) |-> head_job.num_en,
		"digit emitted for a job without a line number")
	`CTF_ASSERT(a_body1_needs_two, (load && cur == PH_BODY1) |-> head_job.body_two,
		"second body byte for a single byte job")

endmodule
